@@ hw/rtl/asia_pkg.sv @@
// Shared codes, types and format helpers for the asynchronous serial adapter.
package asia_pkg;

    // Item commands
    localparam logic [2:0] CMD_TICK          = 3'd0;
    localparam logic [2:0] CMD_WRITE_DATA    = 3'd1;
    localparam logic [2:0] CMD_READ_DATA     = 3'd2;
    localparam logic [2:0] CMD_WRITE_CONTROL = 3'd3;
    localparam logic [2:0] CMD_READ_STATUS   = 3'd4;

    // Transmit line event kinds
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_START  = 3'd1;
    localparam logic [2:0] KIND_DATA   = 3'd2;
    localparam logic [2:0] KIND_PARITY = 3'd3;
    localparam logic [2:0] KIND_STOP   = 3'd4;
    localparam logic [2:0] KIND_BREAK  = 3'd5;

    // Control byte divide select codes
    localparam logic [1:0] DIV_1            = 2'd0;
    localparam logic [1:0] DIV_16           = 2'd1;
    localparam logic [1:0] DIV_64           = 2'd2;
    localparam logic [1:0] DIV_MASTER_RESET = 2'd3;

    // Control byte transmitter control codes
    localparam logic [1:0] TXC_IRQ_ENABLE = 2'd1;
    localparam logic [1:0] TXC_RTS_HIGH   = 2'd2;
    localparam logic [1:0] TXC_BREAK      = 2'd3;

    // Tick counter masks for the divide settings
    localparam logic [5:0] MASK_DIV_1  = 6'd0;
    localparam logic [5:0] MASK_DIV_16 = 6'd15;
    localparam logic [5:0] MASK_DIV_64 = 6'd63;

    typedef enum logic [2:0] {
        RX_IDLE    = 3'd0,
        RX_START   = 3'd1,
        RX_DATA    = 3'd2,
        RX_PAR_BIT = 3'd3,
        RX_STOP    = 3'd4
    } rx_phase_t;

    typedef enum logic [1:0] {
        TX_IDLE   = 2'd0,
        TX_DATA   = 2'd1,
        TX_PARITY = 2'd2,
        TX_STOP   = 2'd3
    } tx_phase_t;

    // Top level to transmitter
    typedef struct packed {
        logic       tick;
        logic       mreset;
        logic [5:0] div_mask;
        logic [2:0] word_sel;
        logic [1:0] tx_ctl;
        logic [7:0] holding;
        logic       holding_empty;
    } tx_ctrl_t;

    // Transmitter to top level
    typedef struct packed {
        logic [2:0] kind;
        logic       line;
        logic       load;
    } tx_stat_t;

    function automatic logic has_parity(input logic [2:0] ws);
        return (ws != 3'd4) && (ws != 3'd5);
    endfunction

    function automatic logic is_even(input logic [2:0] ws);
        return (ws == 3'd0) || (ws == 3'd2) || (ws == 3'd6);
    endfunction

    function automatic logic one_stop(input logic [2:0] ws);
        return (ws >= 3'd2) && (ws != 3'd4);
    endfunction

    // Data bits complete, given the already shifted bit mask
    function automatic logic data_last(input logic [2:0] ws, input logic [7:0] m);
        return (m == 8'h00) || (!ws[2] && (m == 8'h80));
    endfunction

    // Stop bits complete, given the already shifted bit mask
    function automatic logic stop_last(input logic [2:0] ws, input logic [7:0] m);
        return (m == 8'h04) || ((m == 8'h02) && one_stop(ws));
    endfunction

endpackage

@@ hw/rtl/async_serial_interface_adapter_core.sv @@
// Top level of the asynchronous serial adapter: bus registers, receiver, result register.
//
// Each input item is either a serial clock tick or a bus access (write data,
// read data, write control, read status), with the DCD and CTS pin levels.
// Each item gives exactly one result item: read data or status byte, the
// transmit line event of a tick, the interrupt level and the RTS pin.
// The item is processed in the cycle it is accepted and its result sits in
// the output register from the next cycle. Throughput is one item per cycle
// while results are taken. s_ready is high whenever the output register is
// empty or is being drained in the same cycle, so items can follow back to
// back. While a result waits with m_ready low, s_ready is low and the input
// stalls. A stalled result holds its value until taken. Synchronous reset
// clears the control byte, all receiver, transmitter and status state, marks
// the transmit holding register empty and drops the output valid.
// A master reset written through the control byte returns the receiver
// and transmitter to idle and clears the status flags.
module async_serial_interface_adapter_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_command,
    input  logic [7:0] s_write_value,
    input  logic       s_rx_bit,
    input  logic       s_dcd_n,
    input  logic       s_cts_n,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_value,
    output logic [2:0] m_tx_kind,
    output logic       m_tx_bit,
    output logic       m_irq_level,
    output logic       m_rts_n
);

    logic [7:0]          control_reg, control_next;
    logic [5:0]          div_mask_reg, div_mask_next;
    logic [5:0]          rx_count_reg, rx_count_next;
    asia_pkg::rx_phase_t rx_phase_reg, rx_phase_next;
    logic [7:0]          rx_mask_reg, rx_mask_next;
    logic [7:0]          rx_shift_reg, rx_shift_next;
    logic                rx_par_reg, rx_par_next;
    logic                rx_pe_reg, rx_pe_next;
    logic                rx_fe_reg, rx_fe_next;
    logic [7:0]          rx_holding_reg, rx_holding_next;
    logic                rdrf_reg, rdrf_next;
    logic                st_fe_reg, st_fe_next;
    logic                st_pe_reg, st_pe_next;
    logic                ovrn_reg, ovrn_next;
    logic                pending_reg, pending_next;
    logic [7:0]          tx_holding_reg, tx_holding_next;
    logic                tx_empty_reg, tx_empty_next;
    logic                irq_rx_reg, irq_rx_next;
    logic                irq_tx_reg, irq_tx_next;
    logic                prev_dcd_reg, prev_dcd_next;

    logic                out_valid_reg;
    logic [7:0]          out_read_reg;
    logic [2:0]          out_kind_reg;
    logic                out_bit_reg;
    logic                out_irq_reg;
    logic                out_rts_reg;

    logic                accept;
    logic                tick;
    logic [2:0]          word_sel;
    logic                rx_fire;
    logic [7:0]          rx_mask_shifted;
    logic                rx_expect;
    logic                rx_fe_now;
    logic [7:0]          read_value;
    logic                irq_now;
    logic                irq_after;
    asia_pkg::tx_ctrl_t  tx_ctrl;
    asia_pkg::tx_stat_t  tx_stat;

    assign s_ready  = !out_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign tick     = accept && (s_command == asia_pkg::CMD_TICK);
    assign word_sel = control_reg[4:2];
    assign irq_now  = (irq_rx_reg & control_reg[7]) |
                      (irq_tx_reg & (control_reg[6:5] == asia_pkg::TXC_IRQ_ENABLE));

    // Drive the transmitter
    always_comb begin
        tx_ctrl.tick          = tick;
        tx_ctrl.mreset        = accept && (s_command == asia_pkg::CMD_WRITE_CONTROL) &&
                                (s_write_value[1:0] == asia_pkg::DIV_MASTER_RESET);
        tx_ctrl.div_mask      = div_mask_reg;
        tx_ctrl.word_sel      = word_sel;
        tx_ctrl.tx_ctl        = control_reg[6:5];
        tx_ctrl.holding       = tx_holding_reg;
        tx_ctrl.holding_empty = tx_empty_reg;
    end

    asia_tx u_tx (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (tx_ctrl),
        .stat    (tx_stat)
    );

    // Receiver and bus register updates
    always_comb begin
        control_next    = control_reg;
        div_mask_next   = div_mask_reg;
        rx_count_next   = rx_count_reg;
        rx_phase_next   = rx_phase_reg;
        rx_mask_next    = rx_mask_reg;
        rx_shift_next   = rx_shift_reg;
        rx_par_next     = rx_par_reg;
        rx_pe_next      = rx_pe_reg;
        rx_fe_next      = rx_fe_reg;
        rx_holding_next = rx_holding_reg;
        rdrf_next       = rdrf_reg;
        st_fe_next      = st_fe_reg;
        st_pe_next      = st_pe_reg;
        ovrn_next       = ovrn_reg;
        pending_next    = pending_reg;
        tx_holding_next = tx_holding_reg;
        tx_empty_next   = tx_empty_reg;
        irq_rx_next     = irq_rx_reg;
        irq_tx_next     = irq_tx_reg;
        prev_dcd_next   = prev_dcd_reg;
        read_value      = 8'h00;
        rx_fire         = ((rx_count_reg & div_mask_reg) == 6'd0);
        rx_mask_shifted = {rx_mask_reg[6:0], 1'b0};
        rx_expect       = asia_pkg::is_even(word_sel) ? rx_par_reg : ~rx_par_reg;
        rx_fe_now       = rx_fe_reg | ~s_rx_bit;

        if (accept) begin
            case (s_command)
                asia_pkg::CMD_TICK: begin
                    // Track carrier loss on every tick
                    if (!prev_dcd_reg && s_dcd_n) begin
                        irq_rx_next = 1'b1;
                    end
                    prev_dcd_next = s_dcd_n;
                    rx_count_next = rx_count_reg + 6'd1;
                    if (rx_fire) begin
                        case (rx_phase_reg)
                            asia_pkg::RX_IDLE: begin
                                if (!s_dcd_n) begin
                                    rx_phase_next = asia_pkg::RX_START;
                                end
                            end
                            asia_pkg::RX_START: begin
                                if (!s_rx_bit) begin
                                    rx_phase_next = asia_pkg::RX_DATA;
                                    rx_mask_next  = 8'h01;
                                    rx_shift_next = 8'h00;
                                    rx_par_next   = 1'b0;
                                    rx_pe_next    = 1'b0;
                                    rx_fe_next    = 1'b0;
                                end
                            end
                            asia_pkg::RX_DATA: begin
                                if (s_rx_bit) begin
                                    rx_shift_next = rx_shift_reg | rx_mask_reg;
                                    rx_par_next   = ~rx_par_reg;
                                end
                                if (asia_pkg::data_last(word_sel, rx_mask_shifted)) begin
                                    rx_mask_next  = 8'h01;
                                    rx_phase_next = asia_pkg::has_parity(word_sel) ?
                                                    asia_pkg::RX_PAR_BIT : asia_pkg::RX_STOP;
                                end else begin
                                    rx_mask_next = rx_mask_shifted;
                                end
                            end
                            asia_pkg::RX_PAR_BIT: begin
                                if (rx_expect != s_rx_bit) begin
                                    rx_pe_next = 1'b1;
                                end
                                rx_phase_next = asia_pkg::RX_STOP;
                                rx_mask_next  = 8'h01;
                            end
                            asia_pkg::RX_STOP: begin
                                rx_fe_next   = rx_fe_now;
                                rx_mask_next = rx_mask_shifted;
                                if (asia_pkg::stop_last(word_sel, rx_mask_shifted)) begin
                                    rx_phase_next = asia_pkg::RX_START;
                                    // Drop the frame on overrun
                                    if (rdrf_reg) begin
                                        pending_next = 1'b1;
                                    end else begin
                                        rdrf_next       = 1'b1;
                                        rx_holding_next = rx_shift_reg;
                                        st_fe_next      = rx_fe_now;
                                        st_pe_next      = rx_pe_reg;
                                    end
                                    irq_rx_next = 1'b1;
                                end
                            end
                            default: begin
                                rx_phase_next = rx_phase_reg;
                            end
                        endcase
                    end
                    // Take the transmit holding byte when the transmitter loads
                    if (tx_stat.load) begin
                        tx_empty_next = 1'b1;
                        irq_tx_next   = 1'b1;
                    end
                end
                asia_pkg::CMD_WRITE_DATA: begin
                    tx_holding_next = s_write_value;
                    tx_empty_next   = 1'b0;
                    irq_tx_next     = 1'b0;
                end
                asia_pkg::CMD_READ_DATA: begin
                    rdrf_next    = 1'b0;
                    irq_rx_next  = 1'b0;
                    ovrn_next    = pending_reg;
                    pending_next = 1'b0;
                    read_value   = rx_holding_reg;
                end
                asia_pkg::CMD_WRITE_CONTROL: begin
                    control_next = s_write_value;
                    unique case (s_write_value[1:0])
                        asia_pkg::DIV_1:  div_mask_next = asia_pkg::MASK_DIV_1;
                        asia_pkg::DIV_16: div_mask_next = asia_pkg::MASK_DIV_16;
                        asia_pkg::DIV_64: div_mask_next = asia_pkg::MASK_DIV_64;
                        asia_pkg::DIV_MASTER_RESET: begin
                            tx_empty_next = 1'b1;
                            rx_phase_next = asia_pkg::RX_IDLE;
                            rdrf_next     = 1'b0;
                            st_fe_next    = 1'b0;
                            st_pe_next    = 1'b0;
                            ovrn_next     = 1'b0;
                        end
                        default: div_mask_next = div_mask_reg;
                    endcase
                end
                asia_pkg::CMD_READ_STATUS: begin
                    read_value = {1'b0, st_pe_reg, ovrn_reg, st_fe_reg,
                                  s_cts_n, s_dcd_n, 1'b0, rdrf_reg};
                    if (control_reg[1:0] != asia_pkg::DIV_MASTER_RESET) begin
                        read_value[1] = tx_empty_reg & ~s_cts_n;
                        read_value[7] = irq_now;
                    end
                end
                default: begin
                    read_value = 8'h00;
                end
            endcase
        end
    end

    // Interrupt level after this item's update
    assign irq_after = (irq_rx_next & control_next[7]) |
                       (irq_tx_next & (control_next[6:5] == asia_pkg::TXC_IRQ_ENABLE));

    // Hold adapter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            control_reg    <= '0;
            div_mask_reg   <= '0;
            rx_count_reg   <= '0;
            rx_phase_reg   <= asia_pkg::RX_IDLE;
            rx_mask_reg    <= '0;
            rx_shift_reg   <= '0;
            rx_par_reg     <= 1'b0;
            rx_pe_reg      <= 1'b0;
            rx_fe_reg      <= 1'b0;
            rx_holding_reg <= '0;
            rdrf_reg       <= 1'b0;
            st_fe_reg      <= 1'b0;
            st_pe_reg      <= 1'b0;
            ovrn_reg       <= 1'b0;
            pending_reg    <= 1'b0;
            tx_holding_reg <= '0;
            tx_empty_reg   <= 1'b1;
            irq_rx_reg     <= 1'b0;
            irq_tx_reg     <= 1'b0;
            prev_dcd_reg   <= 1'b0;
        end else begin
            control_reg    <= control_next;
            div_mask_reg   <= div_mask_next;
            rx_count_reg   <= rx_count_next;
            rx_phase_reg   <= rx_phase_next;
            rx_mask_reg    <= rx_mask_next;
            rx_shift_reg   <= rx_shift_next;
            rx_par_reg     <= rx_par_next;
            rx_pe_reg      <= rx_pe_next;
            rx_fe_reg      <= rx_fe_next;
            rx_holding_reg <= rx_holding_next;
            rdrf_reg       <= rdrf_next;
            st_fe_reg      <= st_fe_next;
            st_pe_reg      <= st_pe_next;
            ovrn_reg       <= ovrn_next;
            pending_reg    <= pending_next;
            tx_holding_reg <= tx_holding_next;
            tx_empty_reg   <= tx_empty_next;
            irq_rx_reg     <= irq_rx_next;
            irq_tx_reg     <= irq_tx_next;
            prev_dcd_reg   <= prev_dcd_next;
        end
    end

    // Output valid: set on accept, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_ready) begin
            out_valid_reg <= accept;
        end
    end

    // Load the result item on accept, hold it while stalled
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_read_reg <= read_value;
            out_kind_reg <= tx_stat.kind;
            out_bit_reg  <= tx_stat.line;
            out_irq_reg  <= irq_after;
            out_rts_reg  <= (control_next[6:5] == asia_pkg::TXC_RTS_HIGH);
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_read_value = out_read_reg;
    assign m_tx_kind    = out_kind_reg;
    assign m_tx_bit     = out_bit_reg;
    assign m_irq_level  = out_irq_reg;
    assign m_rts_n      = out_rts_reg;

endmodule

@@ hw/rtl/asia_tx.sv @@
// Transmitter of the serial adapter: divided tick, framing and parity generation.
module asia_tx (
    input  logic              aclk,
    input  logic              aresetn,
    input  asia_pkg::tx_ctrl_t ctrl,
    output asia_pkg::tx_stat_t stat
);

    logic [5:0]          tick_count_reg, tick_count_next;
    asia_pkg::tx_phase_t phase_reg, phase_next;
    logic [7:0]          bit_mask_reg, bit_mask_next;
    logic [7:0]          shift_reg, shift_next;
    logic                parity_reg, parity_next;
    logic                fire;
    logic                data_bit;
    logic [7:0]          mask_shifted;

    // Advance the frame on divided ticks
    always_comb begin
        tick_count_next = tick_count_reg;
        phase_next      = phase_reg;
        bit_mask_next   = bit_mask_reg;
        shift_next      = shift_reg;
        parity_next     = parity_reg;
        stat            = '0;
        fire            = ((tick_count_reg & ctrl.div_mask) == 6'd0);
        data_bit        = |(shift_reg & bit_mask_reg);
        mask_shifted    = {bit_mask_reg[6:0], 1'b0};
        if (ctrl.mreset) begin
            phase_next = asia_pkg::TX_IDLE;
        end else if (ctrl.tick) begin
            tick_count_next = tick_count_reg + 6'd1;
            if (fire) begin
                unique case (phase_reg)
                    asia_pkg::TX_IDLE: begin
                        if (ctrl.tx_ctl == asia_pkg::TXC_BREAK) begin
                            stat.kind = asia_pkg::KIND_BREAK;
                        end else if (!ctrl.holding_empty) begin
                            shift_next    = ctrl.holding;
                            stat.load     = 1'b1;
                            phase_next    = asia_pkg::TX_DATA;
                            bit_mask_next = 8'h01;
                            parity_next   = 1'b0;
                            stat.kind     = asia_pkg::KIND_START;
                        end
                    end
                    asia_pkg::TX_DATA: begin
                        stat.kind   = asia_pkg::KIND_DATA;
                        stat.line   = data_bit;
                        parity_next = parity_reg ^ data_bit;
                        if (asia_pkg::data_last(ctrl.word_sel, mask_shifted)) begin
                            bit_mask_next = 8'h01;
                            phase_next    = asia_pkg::has_parity(ctrl.word_sel) ?
                                            asia_pkg::TX_PARITY : asia_pkg::TX_STOP;
                        end else begin
                            bit_mask_next = mask_shifted;
                        end
                    end
                    asia_pkg::TX_PARITY: begin
                        stat.kind     = asia_pkg::KIND_PARITY;
                        stat.line     = asia_pkg::is_even(ctrl.word_sel) ?
                                        parity_reg : ~parity_reg;
                        bit_mask_next = 8'h01;
                        phase_next    = asia_pkg::TX_STOP;
                    end
                    asia_pkg::TX_STOP: begin
                        stat.kind     = asia_pkg::KIND_STOP;
                        stat.line     = 1'b1;
                        bit_mask_next = mask_shifted;
                        if (asia_pkg::stop_last(ctrl.word_sel, mask_shifted)) begin
                            phase_next = asia_pkg::TX_IDLE;
                        end
                    end
                    default: begin
                        phase_next = asia_pkg::TX_IDLE;
                    end
                endcase
            end
        end
    end

    // Hold transmitter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg <= '0;
            phase_reg      <= asia_pkg::TX_IDLE;
            bit_mask_reg   <= '0;
            shift_reg      <= '0;
            parity_reg     <= 1'b0;
        end else begin
            tick_count_reg <= tick_count_next;
            phase_reg      <= phase_next;
            bit_mask_reg   <= bit_mask_next;
            shift_reg      <= shift_next;
            parity_reg     <= parity_next;
        end
    end

endmodule

@@ bench/tb_async_serial_interface_adapter_core.sv @@
// Self-checking bench for the serial adapter core: directed table, then framed random traffic.
module tb_async_serial_interface_adapter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_WAIT      = 6;
    localparam int TAIL_CYCLES   = 8;
    localparam int HOLD_INTERVAL = 400;
    localparam int CALM_INTERVAL = 100;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] wval;
        logic       rxb;
        logic       dcd;
        logic       cts;
    } serial_item_t;

    typedef struct packed {
        logic [7:0] rdv;
        logic [2:0] kind;
        logic       bitv;
        logic       irq;
        logic       rts;
    } adapter_result_t;

    typedef struct packed {
        serial_item_t    it;
        logic            known;
        adapter_result_t want;
    } plan_row_t;

    typedef struct packed {
        logic parity;
        logic even;
        logic two_stop;
        logic eight;
    } word_fmt_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [2:0] s_command;
    logic [7:0] s_write_value;
    logic       s_rx_bit;
    logic       s_dcd_n;
    logic       s_cts_n;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_read_value;
    logic [2:0] m_tx_kind;
    logic       m_tx_bit;
    logic       m_irq_level;
    logic       m_rts_n;

    async_serial_interface_adapter_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_write_value (s_write_value),
        .s_rx_bit      (s_rx_bit),
        .s_dcd_n       (s_dcd_n),
        .s_cts_n       (s_cts_n),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_value  (m_read_value),
        .m_tx_kind     (m_tx_kind),
        .m_tx_bit      (m_tx_bit),
        .m_irq_level   (m_irq_level),
        .m_rts_n       (m_rts_n)
    );

    // Shadow state of the adapter
    logic [7:0]          ctl_q;
    logic [5:0]          div_mask;
    logic [5:0]          rx_cnt;
    logic [5:0]          tx_cnt;
    asia_pkg::rx_phase_t rx_ph;
    logic [7:0]          rx_mask;
    logic [7:0]          rx_sr;
    logic [7:0]          rx_hold;
    logic                rx_par, rx_pe, rx_fe;
    logic                sf_rdrf, sf_fe, sf_pe, sf_ovrn;
    logic                ovr_pend;
    logic [7:0]          tx_hold;
    logic                tx_empty;
    asia_pkg::tx_phase_t tx_ph;
    logic [7:0]          tx_mask;
    logic [7:0]          tx_sr;
    logic                tx_par;
    logic                cause_rx, cause_tx;
    logic                last_dcd;

    adapter_result_t awaited_results[$];
    plan_row_t       plan_rows[$];
    bit              rx_line_bits[$];

    logic [2:0] gen_word;
    int         line_bit_ticks;
    bit         calm;
    bit         run_live;
    int         fail_cnt;
    int         items_sent;
    int         ticks_sent;
    int         frames_made;
    int         results_checked;
    int         cycle_cnt;

    // Decode the word select field of the control byte
    function automatic word_fmt_t decode_word(input logic [2:0] ws);
        word_fmt_t f;
        f.eight = ws[2];
        case (ws)
            3'd0:    begin f.parity = 1'b1; f.even = 1'b1; f.two_stop = 1'b1; end
            3'd1:    begin f.parity = 1'b1; f.even = 1'b0; f.two_stop = 1'b1; end
            3'd2:    begin f.parity = 1'b1; f.even = 1'b1; f.two_stop = 1'b0; end
            3'd3:    begin f.parity = 1'b1; f.even = 1'b0; f.two_stop = 1'b0; end
            3'd4:    begin f.parity = 1'b0; f.even = 1'b0; f.two_stop = 1'b1; end
            3'd5:    begin f.parity = 1'b0; f.even = 1'b0; f.two_stop = 1'b0; end
            3'd6:    begin f.parity = 1'b1; f.even = 1'b1; f.two_stop = 1'b0; end
            default: begin f.parity = 1'b1; f.even = 1'b0; f.two_stop = 1'b0; end
        endcase
        return f;
    endfunction

    // Data bits are done once the shifted mask leaves the word
    function automatic logic data_bits_done(input logic [7:0] m);
        word_fmt_t f;
        f = decode_word(ctl_q[4:2]);
        return (m == 8'h00) || (!f.eight && m == 8'h80);
    endfunction

    function automatic logic stop_bits_done(input logic [7:0] m);
        word_fmt_t f;
        f = decode_word(ctl_q[4:2]);
        return (m == 8'h04) || (m == 8'h02 && !f.two_stop);
    endfunction

    function automatic logic irq_now();
        return (cause_rx & ctl_q[7]) |
               (cause_tx & (ctl_q[6:5] == asia_pkg::TXC_IRQ_ENABLE));
    endfunction

    // Advance the receiver by one serial tick
    function automatic void rx_step(input logic rxb, input logic dcd);
        logic      fire;
        logic      want_par;
        word_fmt_t f;
        f = decode_word(ctl_q[4:2]);
        if (!last_dcd && dcd) cause_rx = 1'b1;
        last_dcd = dcd;
        fire = (rx_cnt & div_mask) == 6'd0;
        rx_cnt = rx_cnt + 6'd1;
        if (fire) begin
            case (rx_ph)
                asia_pkg::RX_IDLE: begin
                    if (!dcd) rx_ph = asia_pkg::RX_START;
                end
                asia_pkg::RX_START: begin
                    if (!rxb) begin
                        rx_ph = asia_pkg::RX_DATA;
                        rx_mask = 8'h01;
                        rx_sr = 8'h00;
                        rx_par = 1'b0;
                        rx_pe = 1'b0;
                        rx_fe = 1'b0;
                    end
                end
                asia_pkg::RX_DATA: begin
                    if (rxb) begin
                        rx_sr = rx_sr | rx_mask;
                        rx_par = ~rx_par;
                    end
                    rx_mask = rx_mask << 1;
                    if (data_bits_done(rx_mask)) begin
                        rx_mask = 8'h01;
                        rx_ph = f.parity ? asia_pkg::RX_PAR_BIT : asia_pkg::RX_STOP;
                    end
                end
                asia_pkg::RX_PAR_BIT: begin
                    want_par = f.even ? rx_par : ~rx_par;
                    if (want_par != rxb) rx_pe = 1'b1;
                    rx_ph = asia_pkg::RX_STOP;
                    rx_mask = 8'h01;
                end
                asia_pkg::RX_STOP: begin
                    if (!rxb) rx_fe = 1'b1;
                    rx_mask = rx_mask << 1;
                    if (stop_bits_done(rx_mask)) begin
                        rx_ph = asia_pkg::RX_START;
                        // Drop the frame while the last one is still unread
                        if (sf_rdrf) begin
                            ovr_pend = 1'b1;
                        end else begin
                            sf_rdrf = 1'b1;
                            rx_hold = rx_sr;
                            sf_fe = rx_fe;
                            sf_pe = rx_pe;
                        end
                        cause_rx = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    endfunction

    // Advance the transmitter by one serial tick
    function automatic void tx_step(output logic [2:0] kind, output logic bitv);
        logic      fire;
        word_fmt_t f;
        f = decode_word(ctl_q[4:2]);
        fire = (tx_cnt & div_mask) == 6'd0;
        tx_cnt = tx_cnt + 6'd1;
        kind = asia_pkg::KIND_NONE;
        bitv = 1'b0;
        if (fire) begin
            case (tx_ph)
                asia_pkg::TX_IDLE: begin
                    if (ctl_q[6:5] == asia_pkg::TXC_BREAK) begin
                        kind = asia_pkg::KIND_BREAK;
                    end else if (!tx_empty) begin
                        tx_sr = tx_hold;
                        tx_empty = 1'b1;
                        cause_tx = 1'b1;
                        tx_ph = asia_pkg::TX_DATA;
                        tx_mask = 8'h01;
                        tx_par = 1'b0;
                        kind = asia_pkg::KIND_START;
                    end
                end
                asia_pkg::TX_DATA: begin
                    bitv = (tx_sr & tx_mask) != 8'h00;
                    kind = asia_pkg::KIND_DATA;
                    tx_par = tx_par ^ bitv;
                    tx_mask = tx_mask << 1;
                    if (data_bits_done(tx_mask)) begin
                        tx_mask = 8'h01;
                        tx_ph = f.parity ? asia_pkg::TX_PARITY : asia_pkg::TX_STOP;
                    end
                end
                asia_pkg::TX_PARITY: begin
                    bitv = f.even ? tx_par : ~tx_par;
                    kind = asia_pkg::KIND_PARITY;
                    tx_mask = 8'h01;
                    tx_ph = asia_pkg::TX_STOP;
                end
                default: begin
                    tx_mask = tx_mask << 1;
                    if (stop_bits_done(tx_mask)) tx_ph = asia_pkg::TX_IDLE;
                    kind = asia_pkg::KIND_STOP;
                    bitv = 1'b1;
                end
            endcase
        end
    endfunction

    // Work out the result of one accepted item and update the shadow state
    function automatic adapter_result_t acia_execute(input serial_item_t it);
        adapter_result_t res;
        logic [2:0]      k;
        logic            b;
        res = '0;
        case (it.cmd)
            asia_pkg::CMD_TICK: begin
                rx_step(it.rxb, it.dcd);
                tx_step(k, b);
                res.kind = k;
                res.bitv = b;
            end
            asia_pkg::CMD_WRITE_DATA: begin
                tx_hold = it.wval;
                tx_empty = 1'b0;
                cause_tx = 1'b0;
            end
            asia_pkg::CMD_READ_DATA: begin
                sf_rdrf = 1'b0;
                cause_rx = 1'b0;
                sf_ovrn = ovr_pend;
                ovr_pend = 1'b0;
                res.rdv = rx_hold;
            end
            asia_pkg::CMD_WRITE_CONTROL: begin
                ctl_q = it.wval;
                case (it.wval[1:0])
                    asia_pkg::DIV_1:  div_mask = asia_pkg::MASK_DIV_1;
                    asia_pkg::DIV_16: div_mask = asia_pkg::MASK_DIV_16;
                    asia_pkg::DIV_64: div_mask = asia_pkg::MASK_DIV_64;
                    default: begin
                        // Master reset keeps the divide mask, counters and causes
                        tx_ph = asia_pkg::TX_IDLE;
                        tx_empty = 1'b1;
                        rx_ph = asia_pkg::RX_IDLE;
                        sf_rdrf = 1'b0;
                        sf_fe = 1'b0;
                        sf_pe = 1'b0;
                        sf_ovrn = 1'b0;
                    end
                endcase
            end
            asia_pkg::CMD_READ_STATUS: begin
                res.rdv = {1'b0, sf_pe, sf_ovrn, sf_fe, it.cts, it.dcd, 1'b0, sf_rdrf};
                if (ctl_q[1:0] != asia_pkg::DIV_MASTER_RESET) begin
                    res.rdv[1] = tx_empty & ~it.cts;
                    res.rdv[7] = irq_now();
                end
            end
            default: ;
        endcase
        res.irq = irq_now();
        res.rts = ctl_q[6:5] == asia_pkg::TXC_RTS_HIGH;
        return res;
    endfunction

    function automatic void plan(input logic [2:0] cmd, input logic [7:0] wval,
                                 input logic rxb, input logic dcd, input logic cts);
        plan_row_t row;
        row.it = '{cmd, wval, rxb, dcd, cts};
        row.known = 1'b0;
        row.want = '0;
        plan_rows.push_back(row);
    endfunction

    function automatic void plan_known(input logic [2:0] cmd, input logic [7:0] wval,
                                       input logic rxb, input logic dcd, input logic cts,
                                       input logic [7:0] rdv, input logic [2:0] kind,
                                       input logic bitv, input logic irq, input logic rts);
        plan_row_t row;
        row.it = '{cmd, wval, rxb, dcd, cts};
        row.known = 1'b1;
        row.want = '{rdv, kind, bitv, irq, rts};
        plan_rows.push_back(row);
    endfunction

    // Hold one line level for the length of one serial bit
    function automatic void push_line_bit(input bit b);
        for (int i = 0; i < line_bit_ticks; i++) rx_line_bits.push_back(b);
    endfunction

    // Queue the receive line for one frame in the current format, or a little noise
    function automatic void queue_rx_frame();
        logic [7:0] data;
        logic       par;
        int         nbits;
        word_fmt_t  f;
        f = decode_word(gen_word);
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 4)) push_line_bit(1'($urandom_range(0, 1)));
        end else begin
            data = 8'($urandom_range(0, 255));
            nbits = f.eight ? 8 : 7;
            par = 1'b0;
            push_line_bit(1'b0);
            for (int i = 0; i < nbits; i++) begin
                push_line_bit(data[i]);
                par = par ^ data[i];
            end
            // Mostly correct parity, now and then a broken one
            if (f.parity) push_line_bit((f.even ? par : ~par) ^ ($urandom_range(0, 9) == 0));
            repeat (f.two_stop ? 2 : 1) push_line_bit($urandom_range(0, 11) != 0);
            repeat ($urandom_range(0, 3)) push_line_bit(1'b1);
            frames_made++;
        end
    endfunction

    // Draw one random item, ticks carrying the framed receive line
    function automatic serial_item_t draw_item();
        serial_item_t it;
        int           pick;
        int           dsel;
        pick = $urandom_range(0, 99);
        it.wval = 8'($urandom_range(0, 255));
        it.rxb = 1'($urandom_range(0, 1));
        it.dcd = $urandom_range(0, 29) == 0;
        it.cts = $urandom_range(0, 3) == 0;
        if (pick < 62) begin
            it.cmd = asia_pkg::CMD_TICK;
            if (rx_line_bits.size() == 0) queue_rx_frame();
            it.rxb = rx_line_bits.pop_front();
        end else if (pick < 70) begin
            it.cmd = asia_pkg::CMD_WRITE_DATA;
        end else if (pick < 80) begin
            it.cmd = asia_pkg::CMD_READ_DATA;
        end else if (pick < 90) begin
            it.cmd = asia_pkg::CMD_READ_STATUS;
        end else if (pick < 94) begin
            it.cmd = asia_pkg::CMD_WRITE_CONTROL;
            // Favor the fast divide so that frames complete often
            dsel = $urandom_range(0, 99);
            if (dsel < 70) begin
                it.wval[1:0] = asia_pkg::DIV_1;
                line_bit_ticks = 1;
            end else if (dsel < 85) begin
                it.wval[1:0] = asia_pkg::DIV_16;
                line_bit_ticks = 16;
            end else if (dsel < 90) begin
                it.wval[1:0] = asia_pkg::DIV_64;
                line_bit_ticks = 64;
            end else begin
                it.wval[1:0] = asia_pkg::DIV_MASTER_RESET;
            end
            gen_word = it.wval[4:2];
        end else begin
            it.cmd = CMD_FIRST_UNUSED + 3'($urandom_range(0, 2));
        end
        return it;
    endfunction

    // Offer one item, wait for it to be taken and record what it should give
    task automatic send_item(input serial_item_t it, input bit hold_off, input bit known,
                             input adapter_result_t want);
        int              gap;
        adapter_result_t pred;
        gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (hold_off || gap > 0) begin
            s_valid <= 1'b0;
            if (hold_off) begin
                do @(posedge aclk); while (awaited_results.size() != 0);
            end
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= it.cmd;
        s_write_value <= it.wval;
        s_rx_bit <= it.rxb;
        s_dcd_n <= it.dcd;
        s_cts_n <= it.cts;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = acia_execute(it);
        awaited_results.push_back(known ? want : pred);
        items_sent++;
        if (it.cmd == asia_pkg::CMD_TICK) ticks_sent++;
    endtask

    // Free-running clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Stop a run that hangs
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Take results with random stalls and compare them in order
    initial begin : result_check
        adapter_result_t got;
        adapter_result_t want;
        int              stall;
        wait (run_live);
        forever begin
            stall = calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            got = '{m_read_value, m_tx_kind, m_tx_bit, m_irq_level, m_rts_n};
            if (awaited_results.size() == 0) begin
                $error("result item with none expected: %p", got);
                fail_cnt++;
            end else begin
                want = awaited_results.pop_front();
                results_checked++;
                if (got.rdv !== want.rdv) begin
                    $error("read_value: expected %02h, got %02h", want.rdv, got.rdv);
                    fail_cnt++;
                end
                if (got.kind !== want.kind) begin
                    $error("tx_kind: expected %0d, got %0d", want.kind, got.kind);
                    fail_cnt++;
                end
                if (got.bitv !== want.bitv) begin
                    $error("tx_bit: expected %0b, got %0b", want.bitv, got.bitv);
                    fail_cnt++;
                end
                if (got.irq !== want.irq) begin
                    $error("irq_level: expected %0b, got %0b", want.irq, got.irq);
                    fail_cnt++;
                end
                if (got.rts !== want.rts) begin
                    $error("rts_n: expected %0b, got %0b", want.rts, got.rts);
                    fail_cnt++;
                end
            end
        end
    end

    // Reset, directed table, random traffic, drain
    initial begin : stimulus
        plan_row_t    row;
        serial_item_t it;
        logic [7:0]   frame;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_command <= asia_pkg::CMD_TICK;
        s_write_value <= 8'h00;
        s_rx_bit <= 1'b1;
        s_dcd_n <= 1'b0;
        s_cts_n <= 1'b0;
        m_ready <= 1'b0;
        fail_cnt = 0;
        items_sent = 0;
        ticks_sent = 0;
        frames_made = 0;
        results_checked = 0;
        calm = 1'b0;
        run_live = 1'b0;
        gen_word = 3'd0;
        line_bit_ticks = 1;

        // Shadow state after reset
        ctl_q = 8'h00;
        div_mask = asia_pkg::MASK_DIV_1;
        rx_cnt = 6'd0;
        tx_cnt = 6'd0;
        rx_ph = asia_pkg::RX_IDLE;
        rx_mask = 8'h00;
        rx_sr = 8'h00;
        rx_hold = 8'h00;
        rx_par = 1'b0;
        rx_pe = 1'b0;
        rx_fe = 1'b0;
        sf_rdrf = 1'b0;
        sf_fe = 1'b0;
        sf_pe = 1'b0;
        sf_ovrn = 1'b0;
        ovr_pend = 1'b0;
        tx_hold = 8'h00;
        tx_empty = 1'b1;
        tx_ph = asia_pkg::TX_IDLE;
        tx_mask = 8'h00;
        tx_sr = 8'h00;
        tx_par = 1'b0;
        cause_rx = 1'b0;
        cause_tx = 1'b0;
        last_dcd = 1'b0;

        // Status and data right after reset, unused commands, master reset
        plan_known(asia_pkg::CMD_READ_STATUS, 8'h00, 1'b0, 1'b0, 1'b0,
                   8'h02, asia_pkg::KIND_NONE, 1'b0, 1'b0, 1'b0);
        plan_known(asia_pkg::CMD_READ_STATUS, 8'h00, 1'b0, 1'b1, 1'b1,
                   8'h0C, asia_pkg::KIND_NONE, 1'b0, 1'b0, 1'b0);
        plan_known(asia_pkg::CMD_READ_DATA, 8'h00, 1'b0, 1'b0, 1'b0,
                   8'h00, asia_pkg::KIND_NONE, 1'b0, 1'b0, 1'b0);
        plan_known(CMD_FIRST_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b1,
                   8'h00, asia_pkg::KIND_NONE, 1'b0, 1'b0, 1'b0);
        plan_known(CMD_LAST_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b1,
                   8'h00, asia_pkg::KIND_NONE, 1'b0, 1'b0, 1'b0);
        plan_known(asia_pkg::CMD_WRITE_CONTROL, 8'h03, 1'b0, 1'b0, 1'b0,
                   8'h00, asia_pkg::KIND_NONE, 1'b0, 1'b0, 1'b0);
        // Transmit ready and interrupt read as zero under master reset
        plan_known(asia_pkg::CMD_READ_STATUS, 8'h00, 1'b0, 1'b1, 1'b0,
                   8'h04, asia_pkg::KIND_NONE, 1'b0, 1'b0, 1'b0);
        plan_known(asia_pkg::CMD_WRITE_CONTROL, 8'h60, 1'b0, 1'b0, 1'b0,
                   8'h00, asia_pkg::KIND_NONE, 1'b0, 1'b0, 1'b0);
        // Break goes out from idle regardless of CTS
        plan_known(asia_pkg::CMD_TICK, 8'h00, 1'b1, 1'b0, 1'b1,
                   8'h00, asia_pkg::KIND_BREAK, 1'b0, 1'b0, 1'b0);
        plan_known(asia_pkg::CMD_WRITE_CONTROL, 8'h40, 1'b0, 1'b0, 1'b0,
                   8'h00, asia_pkg::KIND_NONE, 1'b0, 1'b0, 1'b1);

        // One 8N1 frame each way with interrupts on, then carrier loss
        plan(asia_pkg::CMD_WRITE_CONTROL, 8'hB4, 1'b0, 1'b0, 1'b0);
        plan(asia_pkg::CMD_WRITE_DATA, 8'hFF, 1'b0, 1'b0, 1'b0);
        frame = 8'h4D;
        plan(asia_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0);
        for (int i = 0; i < 8; i++) plan(asia_pkg::CMD_TICK, 8'h00, frame[i], 1'b0, 1'b0);
        plan(asia_pkg::CMD_TICK, 8'h00, 1'b1, 1'b0, 1'b0);
        plan(asia_pkg::CMD_TICK, 8'h00, 1'b1, 1'b1, 1'b0);
        plan(asia_pkg::CMD_TICK, 8'h00, 1'b1, 1'b0, 1'b1);
        plan(asia_pkg::CMD_READ_STATUS, 8'h00, 1'b0, 1'b1, 1'b1);
        plan(asia_pkg::CMD_READ_DATA, 8'h00, 1'b0, 1'b0, 1'b0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        run_live = 1'b1;

        // Walk the directed table
        foreach (plan_rows[i]) begin
            row = plan_rows[i];
            send_item(row.it, 1'b0, row.known, row.want);
        end

        // Random traffic, drained to empty now and then
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % CALM_INTERVAL == 0) calm = $urandom_range(0, 3) == 0;
            it = draw_item();
            send_item(it, n % HOLD_INTERVAL == 0, 1'b0, '0);
        end

        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d items, %0d of them serial ticks carrying %0d receive frames.",
                 items_sent, ticks_sent, frames_made);
        $display("Compared %0d result items, %0d field mismatches.", results_checked, fail_cnt);
        if (fail_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
